/* rtl/core/tepq_pkg.sv */
// Package for the timed event priority queue.
// Holds sizes, mode and status codes, and the types shared by the cell chain and the top level.
// No dependencies.
package tepq_pkg;

   localparam int DEPTH      = 16;
   localparam int TAG_WIDTH  = 16;
   localparam int CYCLE_BITS = 64;

   typedef logic [TAG_WIDTH-1:0]  tag_type;
   typedef logic [CYCLE_BITS-1:0] cycle_type;

   // Request modes
   typedef enum logic [1:0] {
      MODE_SCHEDULE = 2'd0,
      MODE_POP      = 2'd1,
      MODE_PROCESS  = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_PAST  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   // Per-cycle action of every cell in the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   // One stored event
   typedef struct packed {
      logic      valid;
      cycle_type cycle;
      tag_type   tag;
   } entry_type;

   // Broadcast from the controller to all cells
   typedef struct packed {
      cell_op_type op;
      cycle_type   key;
      tag_type     tag;
   } cell_ctrl_type;

endpackage

/* rtl/core/tepq_cell.sv */
// One cell of the sorted event chain: holds one event and its valid bit.
// Compares its cycle against the broadcast key and trades entries with its neighbors.
// Depends on tepq_pkg.
module tepq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tepq_pkg::cell_ctrl_type ctrl,
   input  tepq_pkg::entry_type    left_entry,
   input  logic                   left_le,
   input  tepq_pkg::entry_type    right_entry,
   output tepq_pkg::entry_type    cell_entry,
   output logic                   cell_le
);

   logic                valid_ff;
   logic                valid_in;
   tepq_pkg::cycle_type cycle_ff;
   tepq_pkg::cycle_type cycle_in;
   tepq_pkg::tag_type   tag_ff;
   tepq_pkg::tag_type   tag_in;

   // Stored event sorts at or before the key
   assign cell_le = valid_ff && (cycle_ff <= ctrl.key);

   assign cell_entry.valid = valid_ff;
   assign cell_entry.cycle = cycle_ff;
   assign cell_entry.tag   = tag_ff;

   // Next entry: keep, take the new event, or shift from a neighbor
   always_comb begin
      valid_in = valid_ff;
      cycle_in = cycle_ff;
      tag_in   = tag_ff;
      case (ctrl.op)
         tepq_pkg::CELL_INSERT: begin
            if (!cell_le) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  cycle_in = ctrl.key;
                  tag_in   = ctrl.tag;
               end else begin
                  valid_in = left_entry.valid;
                  cycle_in = left_entry.cycle;
                  tag_in   = left_entry.tag;
               end
            end
         end
         tepq_pkg::CELL_REMOVE: begin
            valid_in = right_entry.valid;
            cycle_in = right_entry.cycle;
            tag_in   = right_entry.tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      cycle_ff <= cycle_in;
      tag_ff   <= tag_in;
   end

endmodule

/* rtl/core/timed_event_priority_queue.sv */
// Timed event priority queue: a sorted chain of event cells and its command controller.
// Depends on tepq_pkg and tepq_cell.
// Schedule, pop and the unused mode give one result: the request is captured, worked in the run state,
// and the result is registered; no new request is taken while busy. Process gives one result per due
// event, one chain shift per removed event, then a closing result, with busy high until it is issued.
// Reset clears all valid bits at once (queue empty) and the controller; results cannot be stalled.
module timed_event_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_event_cycle,
   input  logic [15:0] req_event_tag,
   input  logic [63:0] req_now_cycle,
   input  logic [63:0] req_limit_cycle,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_valid,
   output logic [15:0] rsp_out_tag,
   output logic [63:0] rsp_out_cycle,
   output logic        rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   tepq_pkg::mode_type  mode_ff;
   tepq_pkg::cycle_type ecyc_ff;
   tepq_pkg::tag_type   etag_ff;
   tepq_pkg::cycle_type now_ff;
   tepq_pkg::cycle_type limit_ff;
   logic                any_ff, any_in;

   logic        strobe_ff, strobe_in;
   logic [1:0]  status_ff, status_in;
   logic        oval_ff, oval_in;
   logic [15:0] otag_ff, otag_in;
   logic [63:0] ocyc_ff, ocyc_in;
   logic        last_ff, last_in;

   tepq_pkg::cell_ctrl_type ctrl;
   tepq_pkg::entry_type     cell_q  [tepq_pkg::DEPTH];
   logic                    cell_le [tepq_pkg::DEPTH];
   logic [tepq_pkg::DEPTH-1:0] valid_vec;

   logic accept;
   logic full;
   logic empty;
   logic past;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = cell_q[tepq_pkg::DEPTH-1].valid;
   assign empty  = !cell_q[0].valid;
   assign past   = (ecyc_ff < now_ff);

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= tepq_pkg::mode_type'(req_mode);
         ecyc_ff  <= req_event_cycle;
         etag_ff  <= tepq_pkg::tag_type'(req_event_tag);
         now_ff   <= req_now_cycle;
         limit_ff <= req_limit_cycle;
      end
   end

   // Cell chain; head cell sees a virtual always-before neighbor
   generate
      for (genvar i = 0; i < tepq_pkg::DEPTH; i++) begin : g_cell
         tepq_pkg::entry_type left_e;
         tepq_pkg::entry_type right_e;
         logic                left_l;
         if (i == 0) begin : g_head
            assign left_e = '{valid: 1'b1, cycle: '0, tag: '0};
            assign left_l = 1'b1;
         end else begin : g_mid
            assign left_e = cell_q[i-1];
            assign left_l = cell_le[i-1];
         end
         if (i == tepq_pkg::DEPTH-1) begin : g_tail
            assign right_e = '{valid: 1'b0, cycle: '0, tag: '0};
         end else begin : g_body
            assign right_e = cell_q[i+1];
         end
         tepq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_le     (left_l),
            .right_entry (right_e),
            .cell_entry  (cell_q[i]),
            .cell_le     (cell_le[i])
         );
         assign valid_vec[i] = cell_q[i].valid;
      end
   endgenerate

   // Controller: one result per cycle in the run state
   always_comb begin
      state_in  = state_ff;
      any_in    = any_ff;
      strobe_in = 1'b0;
      status_in = tepq_pkg::STATUS_OK;
      oval_in   = 1'b0;
      otag_in   = '0;
      ocyc_in   = '0;
      last_in   = 1'b1;
      ctrl.op   = tepq_pkg::CELL_HOLD;
      ctrl.key  = (mode_ff == tepq_pkg::MODE_PROCESS) ? limit_ff : ecyc_ff;
      ctrl.tag  = etag_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
               any_in   = 1'b0;
            end
         end
         S_RUN: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            case (mode_ff)
               tepq_pkg::MODE_SCHEDULE: begin
                  if (past) begin
                     status_in = tepq_pkg::STATUS_PAST;
                  end else if (full) begin
                     status_in = tepq_pkg::STATUS_FULL;
                  end else begin
                     ctrl.op = tepq_pkg::CELL_INSERT;
                  end
               end
               tepq_pkg::MODE_POP: begin
                  if (empty) begin
                     status_in = tepq_pkg::STATUS_EMPTY;
                  end else begin
                     oval_in = 1'b1;
                     otag_in = 16'(cell_q[0].tag);
                     ocyc_in = cell_q[0].cycle;
                     ctrl.op = tepq_pkg::CELL_REMOVE;
                  end
               end
               tepq_pkg::MODE_PROCESS: begin
                  // head due: emit it and shift, else close out
                  if (cell_le[0]) begin
                     oval_in  = 1'b1;
                     otag_in  = 16'(cell_q[0].tag);
                     ocyc_in  = cell_q[0].cycle;
                     last_in  = 1'b0;
                     any_in   = 1'b1;
                     state_in = S_RUN;
                     ctrl.op  = tepq_pkg::CELL_REMOVE;
                  end else if (!any_ff) begin
                     status_in = tepq_pkg::STATUS_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         any_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         any_ff    <= any_in;
         strobe_ff <= strobe_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      oval_ff   <= oval_in;
      otag_ff   <= otag_in;
      ocyc_ff   <= ocyc_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_valid = oval_ff;
   assign rsp_out_tag   = otag_ff;
   assign rsp_out_cycle = ocyc_ff;
   assign rsp_last      = last_ff;

   // Valid cells stay packed toward the head
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + tepq_pkg::DEPTH'(1)) & valid_vec) == '0)
      else $error("event chain not packed");

   // Head never sorts after its neighbor
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_q[1].valid |-> (cell_q[0].cycle <= cell_q[1].cycle))
      else $error("event chain out of order");

   // A result only follows a cycle of work
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without pending request");

   // Non-closing results always carry an event
   a_mid_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_out_valid && rsp_status == tepq_pkg::STATUS_OK))
      else $error("intermediate result without event");

endmodule

/* bench/timed_event_priority_queue_checker.sv */
// Checker for the timed event priority queue: watches the request and result transfers,
// keeps its own sorted event store to predict each result, and counts mismatches.
// Depends on tepq_pkg for sizes, mode and status codes.
module timed_event_priority_queue_checker
   import tepq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_event_cycle,
   input  logic [15:0] req_event_tag,
   input  logic [63:0] req_now_cycle,
   input  logic [63:0] req_limit_cycle,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_out_valid,
   input  logic [15:0] rsp_out_tag,
   input  logic [63:0] rsp_out_cycle,
   input  logic        rsp_last,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted result
   typedef struct {
      status_type status;
      logic       valid;
      tag_type    tag;
      cycle_type  due;
      logic       last;
   } outcome_type;

   // Predicted event store, packed in slots 0 to stored-1, sorted by due cycle
   cycle_type   event_due[DEPTH];
   tag_type     event_tag[DEPTH];
   int unsigned stored = 0;

   outcome_type awaited_outcomes[$];
   int unsigned mismatches = 0;
   int unsigned outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void push_outcome(input status_type status, input logic valid,
                                        input tag_type tag, input cycle_type due,
                                        input logic last);
      outcome_type rec;
      rec.status = status;
      rec.valid  = valid;
      rec.tag    = tag;
      rec.due    = due;
      rec.last   = last;
      awaited_outcomes.push_back(rec);
   endfunction

   // Take the earliest event out of the store and predict its result
   function automatic void take_head(input logic last);
      push_outcome(STATUS_OK, 1'b1, event_tag[0], event_due[0], last);
      for (int i = 0; i + 1 < stored; i++) begin
         event_due[i] = event_due[i + 1];
         event_tag[i] = event_tag[i + 1];
      end
      stored--;
   endfunction

   // Apply one accepted request to the store and queue up the results it causes
   task automatic update_event_store(input mode_type mode, input cycle_type due,
                                     input tag_type tag, input cycle_type now,
                                     input cycle_type limit);
      int unsigned slot;
      int unsigned drained;
      case (mode)
         MODE_SCHEDULE: begin
            // past check wins over full
            if (due < now) begin
               push_outcome(STATUS_PAST, 1'b0, '0, '0, 1'b1);
            end else if (stored >= DEPTH) begin
               push_outcome(STATUS_FULL, 1'b0, '0, '0, 1'b1);
            end else begin
               // insert after every event due at or before it, so ties stay in order
               slot = 0;
               while (slot < stored && event_due[slot] <= due) slot++;
               for (int i = stored; i > slot; i--) begin
                  event_due[i] = event_due[i - 1];
                  event_tag[i] = event_tag[i - 1];
               end
               event_due[slot] = due;
               event_tag[slot] = tag;
               stored++;
               push_outcome(STATUS_OK, 1'b0, '0, '0, 1'b1);
            end
         end
         MODE_POP: begin
            if (stored == 0) push_outcome(STATUS_EMPTY, 1'b0, '0, '0, 1'b1);
            else take_head(1'b1);
         end
         MODE_PROCESS: begin
            drained = 0;
            while (stored > 0 && event_due[0] <= limit) begin
               take_head(1'b0);
               drained++;
            end
            push_outcome(drained > 0 ? STATUS_OK : STATUS_EMPTY, 1'b0, '0, '0, 1'b1);
         end
         default: push_outcome(STATUS_OK, 1'b0, '0, '0, 1'b1);
      endcase
   endtask

   // Compare results against the oldest prediction, then take in new requests
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         stored = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("unexpected result, status", 64'(rsp_status), '0);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_out_valid !== want.valid)
                  report_mismatch("out_valid", 64'(rsp_out_valid), 64'(want.valid));
               if (rsp_out_tag !== want.tag)
                  report_mismatch("out_tag", 64'(rsp_out_tag), 64'(want.tag));
               if (rsp_out_cycle !== want.due)
                  report_mismatch("out_cycle", rsp_out_cycle, want.due);
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (start && !busy)
            update_event_store(mode_type'(req_mode), req_event_cycle, req_event_tag,
                               req_now_cycle, req_limit_cycle);
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

/* bench/tb_timed_event_priority_queue.sv */
// Testbench top for the timed event priority queue: clock, reset, request stimulus and verdict.
// Depends on tepq_pkg, timed_event_priority_queue and timed_event_priority_queue_checker.
module tb_timed_event_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import tepq_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [63:0] req_event_cycle;
   logic [15:0] req_event_tag;
   logic [63:0] req_now_cycle;
   logic [63:0] req_limit_cycle;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic        rsp_out_valid;
   logic [15:0] rsp_out_tag;
   logic [63:0] rsp_out_cycle;
   logic        rsp_last;

   int unsigned fail_count;
   int unsigned pending_count;

   bit          idle_on = 1'b1;
   int unsigned items_sent = 0;
   cycle_type   base;

   timed_event_priority_queue u_top (.*);

   timed_event_priority_queue_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run
   initial begin
      #200_000;
      $display("status: fail");
      $finish;
   end

   function automatic cycle_type rand_cycle();
      return {$urandom, $urandom};
   endfunction

   // One request transfer, with random idle cycles ahead of it
   task automatic send(input mode_type mode, input cycle_type due, input tag_type tag,
                       input cycle_type now, input cycle_type limit);
      while (idle_on && $urandom_range(0, 99) < 34) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_event_cycle <= due;
      req_event_tag   <= tag;
      req_now_cycle   <= now;
      req_limit_cycle <= limit;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   initial begin
      int unsigned pick;
      cycle_type   now;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_mode        <= MODE_NONE;
      req_event_cycle <= '0;
      req_event_tag   <= '0;
      req_now_cycle   <= '0;
      req_limit_cycle <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, unused mode, extremes, ties, nothing due, full, past and full
      send(MODE_POP, '0, '0, '0, '0);
      send(MODE_PROCESS, '0, '0, '0, '1);
      send(MODE_NONE, '1, '1, '1, '1);
      send(MODE_SCHEDULE, '0, '0, '0, '0);
      send(MODE_SCHEDULE, 64'd5, 16'h1234, 64'd6, '0);
      send(MODE_SCHEDULE, '1, '1, '1, '0);
      send(MODE_SCHEDULE, 64'd100, 16'd1, 64'd100, '0);
      send(MODE_SCHEDULE, 64'd100, 16'd2, 64'd50, '0);
      send(MODE_PROCESS, '0, '0, '0, '0);
      send(MODE_PROCESS, '0, '0, '0, 64'd99);
      send(MODE_POP, '0, '0, '0, '0);
      for (int i = 0; i < 14; i++)
         send(MODE_SCHEDULE, 64'd200 + (i % 5), tag_type'($urandom), 64'd200, '0);
      send(MODE_SCHEDULE, 64'd300, 16'hbeef, 64'd0, '0);
      send(MODE_SCHEDULE, 64'd10, 16'hdead, 64'd20, '0);
      send(MODE_PROCESS, '0, '0, '0, '1);

      // Random: bursts of schedules, pops and process sweeps, with some noise
      base = 64'd1000;
      while (items_sent < 230) begin
         idle_on = !(items_sent >= 120 && items_sent < 180);
         pick = $urandom_range(0, 99);
         if (pick < 5) base = rand_cycle();
         else base = base + $urandom_range(0, 8);
         if (pick < 45) begin
            repeat ($urandom_range(1, 18)) begin
               now = base + $urandom_range(0, 3);
               send(MODE_SCHEDULE, base + $urandom_range(0, 20), tag_type'($urandom),
                    now, rand_cycle());
            end
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 4))
               send(MODE_POP, rand_cycle(), tag_type'($urandom), rand_cycle(), rand_cycle());
         end else if (pick < 88) begin
            if ($urandom_range(0, 7) == 0)
               send(MODE_PROCESS, rand_cycle(), tag_type'($urandom), rand_cycle(), '1);
            else
               send(MODE_PROCESS, rand_cycle(), tag_type'($urandom), rand_cycle(),
                    base + $urandom_range(0, 24));
         end else begin
            send(mode_type'($urandom_range(0, 3)), rand_cycle(), tag_type'($urandom),
                 rand_cycle(), rand_cycle());
         end
      end
      start <= 1'b0;

      // Drain, then watch a while for stray results
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
